[rtl/onewire_rom_search_macros.svh]
// Assertion macros for the ROM search RTL, used by owrs_engine.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ONEWIRE_ROM_SEARCH_MACROS_SVH
`define ONEWIRE_ROM_SEARCH_MACROS_SVH

// Checked at every clock edge outside reset.
`define OWRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, during reset too.
`define OWRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/owrs_pkg.sv]
// Shared types, codes and helper functions for the 1-Wire ROM search engine.
// Used by owrs_engine and onewire_rom_search; depends on nothing.
package owrs_pkg;

  localparam int unsigned RomBits    = 64;
  localparam int unsigned PosBits    = 6;
  localparam int unsigned BranchBits = 7;
  localparam int unsigned DataBits   = 56;
  localparam logic [7:0]  CrcPoly    = 8'h8C;
  localparam logic [BranchBits-1:0] BranchNone = '1;
  localparam logic [PosBits-1:0]    LastPos    = '1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_PAIR  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DEV  = 2'd1,
    ST_NO_PASS = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] command;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic                write_bit;
    logic                pass_end;
    logic [RomBits-1:0]  device_id;
    logic                crc_ok;
    logic                bus_error;
    logic                search_done;
  } result_t;

  // One bit of the reflected Maxim CRC-8, least significant bit first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic din);
    logic fb;
    fb = crc[0] ^ din;
    return fb ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
  endfunction

endpackage

[rtl/owrs_engine.sv]
// Search state and per-command update of the ROM search: branch choice,
// ROM bit update and serial CRC. Depends on owrs_pkg and the assertion macros.
`include "onewire_rom_search_macros.svh"

module owrs_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  owrs_pkg::item_t   item,
  output owrs_pkg::result_t res
);
  import owrs_pkg::*;

  logic [RomBits-1:0]    rom_bits_r, rom_bits_nxt;
  logic [BranchBits-1:0] last_branch_r, last_branch_nxt;
  logic [BranchBits-1:0] pass_branch_r, pass_branch_nxt;
  logic                  finished_r, finished_nxt;
  logic [PosBits-1:0]    bit_pos_r, bit_pos_nxt;
  logic                  in_pass_r, in_pass_nxt;
  logic                  prev_choice_r, prev_choice_nxt;
  logic                  pass_error_r, pass_error_nxt;
  logic [7:0]            crc_r, crc_nxt;

  logic [1:0]            pair;
  logic                  choice;
  logic [RomBits-1:0]    rom_upd;
  logic [7:0]            crc_upd;
  logic                  done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bits_r    <= '0;
      last_branch_r <= BranchNone;
      pass_branch_r <= BranchNone;
      finished_r    <= 1'b0;
      bit_pos_r     <= '0;
      in_pass_r     <= 1'b0;
      prev_choice_r <= 1'b0;
      pass_error_r  <= 1'b0;
      crc_r         <= '0;
    end else if (step) begin
      rom_bits_r    <= rom_bits_nxt;
      last_branch_r <= last_branch_nxt;
      pass_branch_r <= pass_branch_nxt;
      finished_r    <= finished_nxt;
      bit_pos_r     <= bit_pos_nxt;
      in_pass_r     <= in_pass_nxt;
      prev_choice_r <= prev_choice_nxt;
      pass_error_r  <= pass_error_nxt;
      crc_r         <= crc_nxt;
    end
  end

  // Direction choice for the current position.
  always_comb begin
    pair = {item.complement_bit, item.id_bit};
    choice = 1'b0;
    unique case (pair)
      2'b01, 2'b10: choice = item.id_bit;
      2'b11:        choice = prev_choice_r;
      default: begin
        // Devices disagree: a negative last branch lies below every position.
        if (last_branch_r[BranchBits-1]) begin
          choice = 1'b0;
        end else if (bit_pos_r == last_branch_r[PosBits-1:0]) begin
          choice = 1'b1;
        end else if (bit_pos_r < last_branch_r[PosBits-1:0]) begin
          choice = rom_bits_r[bit_pos_r];
        end else begin
          choice = 1'b0;
        end
      end
    endcase

    rom_upd = rom_bits_r;
    rom_upd[bit_pos_r] = choice;
    crc_upd = (bit_pos_r < PosBits'(DataBits)) ? crc8_step(crc_r, choice) : crc_r;
  end

  always_comb begin
    rom_bits_nxt    = rom_bits_r;
    last_branch_nxt = last_branch_r;
    pass_branch_nxt = pass_branch_r;
    finished_nxt    = finished_r;
    bit_pos_nxt     = bit_pos_r;
    in_pass_nxt     = in_pass_r;
    prev_choice_nxt = prev_choice_r;
    pass_error_nxt  = pass_error_r;
    crc_nxt         = crc_r;
    done            = 1'b0;
    res             = '0;
    res.status      = ST_OK;

    unique case (item.command)
      CMD_CLEAR: begin
        rom_bits_nxt    = '0;
        last_branch_nxt = BranchNone;
        finished_nxt    = 1'b0;
        in_pass_nxt     = 1'b0;
      end
      CMD_BEGIN: begin
        if (finished_r || !item.presence) begin
          in_pass_nxt = 1'b0;
          res.status  = ST_NO_DEV;
        end else begin
          in_pass_nxt     = 1'b1;
          bit_pos_nxt     = '0;
          pass_branch_nxt = BranchNone;
          prev_choice_nxt = 1'b0;
          pass_error_nxt  = 1'b0;
          crc_nxt         = '0;
        end
      end
      CMD_PAIR: begin
        if (!in_pass_r) begin
          res.status = ST_NO_PASS;
        end else begin
          if (pair == 2'b00 && !choice) begin
            pass_branch_nxt = {1'b0, bit_pos_r};
          end
          if (pair == 2'b11) begin
            pass_error_nxt = 1'b1;
          end
          rom_bits_nxt    = rom_upd;
          prev_choice_nxt = choice;
          crc_nxt         = crc_upd;
          res.write_bit   = choice;
          bit_pos_nxt     = bit_pos_r + PosBits'(1);
          if (bit_pos_r == LastPos) begin
            done            = (pass_branch_nxt == BranchNone);
            res.pass_end    = 1'b1;
            res.device_id   = rom_upd;
            res.crc_ok      = (crc_upd == rom_upd[RomBits-1:DataBits]);
            res.bus_error   = pass_error_nxt;
            res.search_done = done;
            if (done) begin
              finished_nxt = 1'b1;
            end else begin
              last_branch_nxt = pass_branch_nxt;
            end
            in_pass_nxt = 1'b0;
          end
        end
      end
      default: begin
        // Unused command code: no state change, all-zero result.
      end
    endcase
  end

  `OWRS_ASSERT_ALWAYS(a_finished_no_pass, finished_r |-> !in_pass_r,
                      "search finished while a pass is open")
  `OWRS_ASSERT(a_pass_end_closes, (step && res.pass_end) |=> !in_pass_r,
               "pass still open after its last bit")
  `OWRS_ASSERT(a_done_sets_finished, (step && res.search_done) |=> finished_r,
               "search done reported but finished flag not set")
  `OWRS_ASSERT(a_pass_end_pos, (step && res.pass_end) |-> (bit_pos_r == LastPos && in_pass_r),
               "pass end reported away from the last position")

endmodule

[rtl/onewire_rom_search.sv]
// 1-Wire Search ROM engine, one command in and one result out per transfer.
// Each input transfer yields exactly one result transfer. The block takes a new
// command every clock cycle while in_stall is low; a command is held in the input
// register, then passes through owrs_engine into the result register, which drives
// out_valid. Back-pressure on the result side propagates to in_stall only once
// both registers are full.
// Depends on owrs_pkg and owrs_engine.
module onewire_rom_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic        in_presence,
  input  logic        in_id_bit,
  input  logic        in_complement_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_write_bit,
  output logic        out_pass_end,
  output logic [63:0] out_device_id,
  output logic        out_crc_ok,
  output logic        out_bus_error,
  output logic        out_search_done
);
  import owrs_pkg::*;

  logic    in_valid_r, in_valid_nxt;
  item_t   in_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t eng_res;
  logic    advance;
  logic    in_take;

  // The held command moves into the engine when the result register is empty or its result is taken.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt  = in_take || (in_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= '{command:        in_command,
                     presence:       in_presence,
                     id_bit:         in_id_bit,
                     complement_bit: in_complement_bit};
    end
    if (advance) begin
      out_res_r <= eng_res;
    end
  end

  owrs_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .res   (eng_res)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_write_bit   = out_res_r.write_bit;
  assign out_pass_end    = out_res_r.pass_end;
  assign out_device_id   = out_res_r.device_id;
  assign out_crc_ok      = out_res_r.crc_ok;
  assign out_bus_error   = out_res_r.bus_error;
  assign out_search_done = out_res_r.search_done;

endmodule

[bench/rom_search_checker.sv]
// Scoreboard for the 1-Wire ROM search engine: watches both channels, predicts each
// result from the input transfers and compares it with what the block returns.
// Depends on owrs_pkg for the command, status and result types.
module rom_search_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic        in_presence,
  input  logic        in_id_bit,
  input  logic        in_complement_bit,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic        out_write_bit,
  input  logic        out_pass_end,
  input  logic [63:0] out_device_id,
  input  logic        out_crc_ok,
  input  logic        out_bus_error,
  input  logic        out_search_done,
  output int          mismatches,
  output int          pending,
  output int          results_seen,
  output int          passes_seen,
  output int          searches_ended,
  output int          crc_matches,
  output int          faulty_passes
);
  timeunit 1ns;
  timeprecision 1ps;
  import owrs_pkg::*;

  // Search memory as the block should hold it.
  logic [63:0]       rom_img;
  logic signed [6:0] last_zero;
  logic signed [6:0] pass_zero;
  logic              exhausted;
  logic              pass_open;
  logic              prev_dir;
  logic              pass_fault;
  logic [5:0]        pos;
  logic [7:0]        crc_run;
  result_t           expected_q[$];

  task automatic clear_search_state();
    rom_img    = '0;
    last_zero  = BranchNone;
    pass_zero  = BranchNone;
    exhausted  = 1'b0;
    pass_open  = 1'b0;
    prev_dir   = 1'b0;
    pass_fault = 1'b0;
    pos        = '0;
    crc_run    = '0;
  endtask

  task automatic advance_search(input logic [1:0] cmd, input logic pres, input logic id,
                                input logic comp, output result_t r);
    int   lz;
    logic dir;
    logic fb;
    r   = '0;
    lz  = int'(last_zero);
    dir = 1'b0;
    if (cmd == CMD_CLEAR) begin
      rom_img   = '0;
      last_zero = BranchNone;
      exhausted = 1'b0;
      pass_open = 1'b0;
    end else if (cmd == CMD_BEGIN) begin
      if (exhausted || !pres) begin
        pass_open = 1'b0;
        r.status  = ST_NO_DEV;
      end else begin
        pass_open  = 1'b1;
        pos        = '0;
        pass_zero  = BranchNone;
        prev_dir   = 1'b0;
        pass_fault = 1'b0;
        crc_run    = '0;
      end
    end else if (cmd == CMD_PAIR) begin
      if (!pass_open) begin
        r.status = ST_NO_PASS;
      end else begin
        if (id != comp) begin
          dir = id;
        end else if (!id) begin
          // Devices disagree: follow the tree relative to the previous pass's last
          // zero branch. A negative branch lies below every position.
          if (int'(pos) == lz) dir = 1'b1;
          else if (int'(pos) < lz) dir = rom_img[pos];
          else dir = 1'b0;
          if (!dir) pass_zero = {1'b0, pos};
        end else begin
          dir        = prev_dir;
          pass_fault = 1'b1;
        end
        rom_img[pos] = dir;
        prev_dir     = dir;
        if (pos < DataBits) begin
          fb      = crc_run[0] ^ dir;
          crc_run = {1'b0, crc_run[7:1]} ^ (fb ? CrcPoly : 8'h00);
        end
        r.write_bit = dir;
        if (pos == LastPos) begin
          r.pass_end    = 1'b1;
          r.device_id   = rom_img;
          r.crc_ok      = (crc_run == rom_img[63:56]);
          r.bus_error   = pass_fault;
          r.search_done = (pass_zero == BranchNone);
          if (r.search_done) exhausted = 1'b1;
          else last_zero = pass_zero;
          pass_open = 1'b0;
          pos       = '0;
        end else begin
          pos = pos + 6'd1;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on result %0d: %s got %0h, expected %0h",
             $realtime, results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      clear_search_state();
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        advance_search(in_command, in_presence, in_id_bit, in_complement_bit, want);
        expected_q.push_back(want);
        if (want.pass_end) begin
          passes_seen++;
          if (want.search_done) searches_ended++;
          if (want.crc_ok) crc_matches++;
          if (want.bus_error) faulty_passes++;
        end
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("transfer with nothing expected, status", 64'(out_status), '0);
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_write_bit !== want.write_bit)
            report_mismatch("write_bit", 64'(out_write_bit), 64'(want.write_bit));
          if (out_pass_end !== want.pass_end)
            report_mismatch("pass_end", 64'(out_pass_end), 64'(want.pass_end));
          if (out_device_id !== want.device_id)
            report_mismatch("device_id", out_device_id, want.device_id);
          if (out_crc_ok !== want.crc_ok)
            report_mismatch("crc_ok", 64'(out_crc_ok), 64'(want.crc_ok));
          if (out_bus_error !== want.bus_error)
            report_mismatch("bus_error", 64'(out_bus_error), 64'(want.bus_error));
          if (out_search_done !== want.search_done)
            report_mismatch("search_done", 64'(out_search_done), 64'(want.search_done));
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

[bench/tb_onewire_rom_search.sv]
// Top of the ROM search bench: clock, reset, stimulus on the command channel and
// back-pressure on the result channel. Checking is done by rom_search_checker.
// Depends on owrs_pkg, onewire_rom_search and rom_search_checker.
module tb_onewire_rom_search;
  timeunit 1ns;
  timeprecision 1ps;
  import owrs_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ItemTarget  = 950;
  localparam int CalmFrom    = 860;
  localparam int PressureAt  = 250;
  localparam int PressureLen = 200;
  localparam int CycleLimit  = 200000;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command        = CMD_CLEAR;
  logic        in_presence       = 1'b0;
  logic        in_id_bit         = 1'b0;
  logic        in_complement_bit = 1'b0;
  logic        out_valid;
  logic        out_stall         = 1'b0;
  logic [1:0]  out_status;
  logic        out_write_bit;
  logic        out_pass_end;
  logic [63:0] out_device_id;
  logic        out_crc_ok;
  logic        out_bus_error;
  logic        out_search_done;

  int mismatches;
  int pending;
  int results_seen;
  int passes_seen;
  int searches_ended;
  int crc_matches;
  int faulty_passes;

  int sent   = 0;
  int cycles = 0;
  bit calm   = 1'b0;
  bit gappy  = 1'b1;

  onewire_rom_search uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_presence, .in_id_bit, .in_complement_bit,
    .out_valid, .out_stall, .out_status, .out_write_bit, .out_pass_end, .out_device_id,
    .out_crc_ok, .out_bus_error, .out_search_done
  );

  rom_search_checker search_chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_presence, .in_id_bit, .in_complement_bit,
    .out_valid, .out_stall, .out_status, .out_write_bit, .out_pass_end, .out_device_id,
    .out_crc_ok, .out_bus_error, .out_search_done,
    .mismatches, .pending, .results_seen, .passes_seen, .searches_ended, .crc_matches,
    .faulty_passes
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Builds a code whose top byte is the CRC-8 of the lower seven bytes.
  function automatic logic [63:0] with_crc(input logic [63:0] code);
    logic [7:0] c;
    c = '0;
    for (int i = 0; i < 56; i++)
      c = {1'b0, c[7:1]} ^ ((c[0] ^ code[6'(i)]) ? CrcPoly : 8'h00);
    return {c, code[55:0]};
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic pres, input logic id,
                           input logic comp);
    int unsigned gap;
    if (!calm && gappy && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_presence       <= pres;
    in_id_bit         <= id;
    in_complement_bit <= comp;
    do @(posedge clk); while (in_stall);
    if (cmd != CMD_UNUSED) sent++;
    calm = (sent >= CalmFrom);
  endtask

  task automatic scramble(input int unsigned count);
    logic [1:0] cmd;
    repeat (count) begin
      cmd = 2'($urandom_range(3));
      send_item(cmd, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // One whole search: optional clear, then enough passes to walk a tree whose forks
  // sit at a few random positions, then one more begin that should be refused.
  task automatic run_search(input bit clean);
    logic [63:0] base;
    logic [63:0] forks;
    int unsigned fork_count;
    int unsigned passes;
    base  = {$urandom, $urandom};
    forks = '0;
    if (clean) base = '0;
    else if ($urandom_range(15) == 0) base = '1;
    else if ($urandom_range(1)) base = with_crc(base);
    fork_count = clean ? 0 : (($urandom_range(3) == 0) ? 3 : $urandom_range(0, 2));
    repeat (fork_count) forks[6'($urandom_range(63))] = 1'b1;
    passes = 1 << $countones(forks);
    if (clean || $urandom_range(1)) send_item(CMD_CLEAR, 1'($urandom_range(1)), 1'b0, 1'b0);
    for (int n = 0; n < passes && sent < ItemTarget; n++) begin
      send_item(CMD_BEGIN, clean || ($urandom_range(19) != 0), 1'($urandom_range(1)), 1'b0);
      for (int slot = 0; slot < 64; slot++) begin
        if (!clean && $urandom_range(149) == 0) scramble(1);
        if (forks[6'(slot)]) send_item(CMD_PAIR, 1'($urandom_range(1)), 1'b0, 1'b0);
        else if (!clean && $urandom_range(79) == 0)
          send_item(CMD_PAIR, 1'($urandom_range(1)), 1'b1, 1'b1);
        else send_item(CMD_PAIR, 1'($urandom_range(1)), base[6'(slot)], !base[6'(slot)]);
      end
    end
    send_item(CMD_BEGIN, 1'b1, 1'b0, 1'b0);
  endtask

  initial begin : receiver
    logic        level;
    int unsigned span;
    bit          pressed;
    level   = 1'b0;
    pressed = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (calm) begin
        level = 1'b0;
        span  = 1;
      end else if (!pressed && sent >= PressureAt) begin
        // Long hold-off while the sender keeps offering, so both stages fill up.
        level   = 1'b1;
        span    = PressureLen;
        pressed = 1'b1;
      end else begin
        level = !level;
        if (level) span = $urandom_range(1, 15);
        else if ($urandom_range(7) == 0) span = $urandom_range(60, 120);
        else span = $urandom_range(1, 25);
      end
      out_stall <= level;
      repeat (span) @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: refusals, every pair kind, bus error at the first position,
    // begin in the middle of a pass, clear in the middle of a pass.
    send_item(CMD_PAIR, 1'b1, 1'b1, 1'b0);
    send_item(CMD_BEGIN, 1'b0, 1'b1, 1'b1);
    send_item(CMD_UNUSED, 1'b1, 1'b1, 1'b1);
    send_item(CMD_CLEAR, 1'b0, 1'b0, 1'b0);
    send_item(CMD_BEGIN, 1'b1, 1'b0, 1'b0);
    send_item(CMD_PAIR, 1'b0, 1'b1, 1'b0);
    send_item(CMD_PAIR, 1'b0, 1'b0, 1'b1);
    send_item(CMD_PAIR, 1'b0, 1'b0, 1'b0);
    send_item(CMD_PAIR, 1'b0, 1'b1, 1'b1);
    send_item(CMD_UNUSED, 1'b0, 1'b0, 1'b0);
    send_item(CMD_BEGIN, 1'b1, 1'b1, 1'b0);
    send_item(CMD_PAIR, 1'b1, 1'b1, 1'b1);
    send_item(CMD_PAIR, 1'b1, 1'b1, 1'b0);
    send_item(CMD_CLEAR, 1'b1, 1'b1, 1'b1);
    send_item(CMD_PAIR, 1'b0, 1'b0, 1'b1);
    send_item(CMD_BEGIN, 1'b0, 1'b0, 1'b0);

    // A clean all-zero pass ends the search with a matching CRC.
    run_search(1'b1);
    while (sent < ItemTarget) begin
      gappy = ($urandom_range(2) != 0);
      if ($urandom_range(9) < 7) run_search(1'b0);
      else scramble($urandom_range(20, 40));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d commands and checked %0d results in %0d cycles.",
             sent, results_seen, cycles);
    $display("Saw %0d complete passes: %0d ended a search, %0d with good CRC, %0d bus errors.",
             passes_seen, searches_ended, crc_matches, faulty_passes);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/owrs_pkg.sv
rtl/owrs_engine.sv
rtl/onewire_rom_search.sv
bench/rom_search_checker.sv
bench/tb_onewire_rom_search.sv
